@@ sv/cgwn_pkg.sv @@
// cgwn_pkg: shared widths, fixed-point constants and the command struct
// between the controller and the datapath of the weighted-norm update unit.
// No dependencies.
package cgwn_pkg;

    localparam int DATA_W   = 32;   // Q16.16 vector elements and alpha
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = 17;   // Q1.16 weight
    localparam int NORM_W   = 63;   // unsigned Q31.32 norm

    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    // One command per datapath step; the controller raises at most one a cycle.
    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic do_mul;    // alpha * p and alpha * Ap
        logic do_rnd;    // add, round, saturate, take magnitude
        logic do_sqr;    // square of the new residual
        logic do_wgt;    // two partial products with the weight
        logic do_trm;    // join partials, round, saturate the term
        logic do_acc;    // accumulate and load the output register
    } cmd_t;

endpackage

@@ sv/cgwn_ctrl.sv @@
// cgwn_ctrl: sequencer for the weighted-norm update unit.
// Walks one item through the datapath steps and owns both handshakes.
// Depends on cgwn_pkg.
module cgwn_ctrl
    import cgwn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_WGT  = 3'd4;
    localparam logic [2:0] ST_TRM  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.do_rnd = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.do_sqr = 1'b1;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                cmd.do_wgt = 1'b1;
                state_next = ST_TRM;
            end
            ST_TRM:
            begin
                cmd.do_trm = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // hold until the previous result has been transferred
                if (out_free)
                begin
                    cmd.do_acc     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL))
        else $error("accepted item did not start the multiply step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_acc |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a stalled result waits");

    a_valid_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_ACC))
        else $error("result raised outside the accumulate step");

    a_mul_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_RND))
        else $error("multiply step did not advance");

endmodule

@@ sv/cgwn_dpath.sv @@
// cgwn_dpath: arithmetic of the weighted-norm update unit: alpha register,
// update products, rounding, weighted square and the norm accumulator.
// Depends on cgwn_pkg; stepped by cgwn_ctrl commands.
module cgwn_dpath
    import cgwn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic        [DATA_W-1:0]   cfg_wr_data,
    input  logic signed [DATA_W-1:0]   dir_value,
    input  logic signed [DATA_W-1:0]   op_dir_value,
    input  logic signed [DATA_W-1:0]   sol_value,
    input  logic signed [DATA_W-1:0]   res_value,
    input  logic        [WEIGHT_W-1:0] weight,
    input  logic                       last_item,
    input  cmd_t                       cmd,
    output logic signed [DATA_W-1:0]   new_sol,
    output logic signed [DATA_W-1:0]   new_res,
    output logic                       norm_valid,
    output logic        [NORM_W-1:0]   weighted_norm
);

    // Round an exact Q32.32 sum half up to Q16.16 and saturate.
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [64:0] s);
        logic signed [64:0] t;
        logic signed [48:0] q;
        t = s + 65'sd32768;
        q = t[64:16];
        if (q > 49'sd2147483647)
            round_sat = 32'sh7FFF_FFFF;
        else if (q < -49'sd2147483648)
            round_sat = 32'sh8000_0000;
        else
            round_sat = q[31:0];
    endfunction

    logic signed [DATA_W-1:0]   alpha_reg;
    logic signed [DATA_W-1:0]   p_reg, ap_reg, x_reg, r_reg;
    logic        [WEIGHT_W-1:0] w_reg;
    logic                       last_reg;
    logic signed [63:0]         prod_p_reg, prod_ap_reg;
    logic signed [63:0]         prod_p_next, prod_ap_next;
    logic signed [DATA_W-1:0]   nx_reg, nr_reg, nx_next, nr_next;
    logic        [DATA_W-1:0]   mag_reg, mag_next;
    logic        [NORM_W-1:0]   sq_reg, sq_next;
    logic        [63:0]         sq_full;
    logic        [48:0]         lo_reg, lo_next;
    logic        [47:0]         hi_reg, hi_next;
    logic        [NORM_W-1:0]   term_reg, term_next;
    logic        [79:0]         term_sum;
    logic        [NORM_W-1:0]   acc_reg, acc_next;
    logic        [NORM_W:0]     acc_sum;
    logic        [NORM_W-1:0]   acc_new;
    logic signed [64:0]         sum_x, sum_r;
    logic signed [DATA_W-1:0]   sol_reg, res_reg;
    logic                       nvalid_reg;
    logic        [NORM_W-1:0]   norm_reg;

    always_comb
    begin
        prod_p_next  = 64'(alpha_reg) * 64'(p_reg);
        prod_ap_next = 64'(alpha_reg) * 64'(ap_reg);

        sum_x   = $signed({{17{x_reg[31]}}, x_reg, 16'd0}) + 65'(prod_p_reg);
        sum_r   = $signed({{17{r_reg[31]}}, r_reg, 16'd0}) - 65'(prod_ap_reg);
        nx_next = round_sat(sum_x);
        nr_next = round_sat(sum_r);
        mag_next = nr_next[31] ? (~nr_next + 32'd1) : nr_next;

        sq_full = 64'(mag_reg) * 64'(mag_reg);
        sq_next = sq_full[NORM_W-1:0];

        // split the weighted square into two narrow products
        lo_next = 49'(sq_reg[31:0]) * 49'(w_reg);
        hi_next = 48'(sq_reg[62:32]) * 48'(w_reg);

        term_sum  = {hi_reg, 32'd0} + 80'(lo_reg) + 80'd32768;
        term_next = (term_sum[79:79] != 1'b0) ? NORM_MAX : term_sum[78:16];

        acc_sum = {1'b0, acc_reg} + {1'b0, term_reg};
        acc_new = acc_sum[NORM_W] ? NORM_MAX : acc_sum[NORM_W-1:0];
        acc_next = acc_reg;
        if (cmd.do_acc)
            acc_next = last_reg ? '0 : acc_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                alpha_reg <= cfg_wr_data;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            p_reg    <= dir_value;
            ap_reg   <= op_dir_value;
            x_reg    <= sol_value;
            r_reg    <= res_value;
            w_reg    <= weight;
            last_reg <= last_item;
        end
        if (cmd.do_mul)
        begin
            prod_p_reg  <= prod_p_next;
            prod_ap_reg <= prod_ap_next;
        end
        if (cmd.do_rnd)
        begin
            nx_reg  <= nx_next;
            nr_reg  <= nr_next;
            mag_reg <= mag_next;
        end
        if (cmd.do_sqr)
            sq_reg <= sq_next;
        if (cmd.do_wgt)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (cmd.do_trm)
            term_reg <= term_next;
        if (cmd.do_acc)
        begin
            sol_reg    <= nx_reg;
            res_reg    <= nr_reg;
            nvalid_reg <= last_reg;
            norm_reg   <= last_reg ? acc_new : '0;
        end
    end

    assign new_sol       = sol_reg;
    assign new_res       = res_reg;
    assign norm_valid    = nvalid_reg;
    assign weighted_norm = norm_reg;

endmodule

@@ sv/cg_update_weighted_norm_unit.sv @@
// cg_update_weighted_norm_unit: top level of the CG update with weighted norm.
// Joins the sequencer cgwn_ctrl and the datapath cgwn_dpath; uses cgwn_pkg.
//
//   channel  handshake              payload
//   -------  ---------------------  ----------------------------------------------
//   in       in_valid / in_stall    dir_value op_dir_value sol_value res_value
//                                   weight last_item
//   out      out_valid / out_stall  new_sol new_res norm_valid weighted_norm
//   cfg      cfg_wr_en              cfg_wr_data (step alpha, Q16.16)
//
// One item passes the transfer in, multiply, round, square, weight, term and
// accumulate steps of the single shared datapath, one step a cycle unless stalled.
// The next item is taken in the cycle after the accumulate step.
// A stalled result holds the accumulate step only; a new item may be taken
// while the previous result waits. Reset clears alpha, the norm and the
// control state at once; there is no clearing pass.
module cg_update_weighted_norm_unit
    import cgwn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic        [DATA_W-1:0]   cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [DATA_W-1:0]   dir_value,
    input  logic signed [DATA_W-1:0]   op_dir_value,
    input  logic signed [DATA_W-1:0]   sol_value,
    input  logic signed [DATA_W-1:0]   res_value,
    input  logic        [WEIGHT_W-1:0] weight,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   new_sol,
    output logic signed [DATA_W-1:0]   new_res,
    output logic                       norm_valid,
    output logic        [NORM_W-1:0]   weighted_norm
);

    cmd_t cmd;

    cgwn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cgwn_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .dir_value     (dir_value),
        .op_dir_value  (op_dir_value),
        .sol_value     (sol_value),
        .res_value     (res_value),
        .weight        (weight),
        .last_item     (last_item),
        .cmd           (cmd),
        .new_sol       (new_sol),
        .new_res       (new_res),
        .norm_valid    (norm_valid),
        .weighted_norm (weighted_norm)
    );

endmodule

@@ tb/cg_update_weighted_norm_unit_tb.sv @@
// Testbench for cg_update_weighted_norm_unit: drives the CG update and norm stream
// through random idle and stall patterns and checks every result against a local predictor.
// Depends on cgwn_pkg and the RTL of cg_update_weighted_norm_unit.
module cg_update_weighted_norm_unit_tb;
    import cgwn_pkg::*;

    localparam int EXT_W        = 2 * DATA_W + 2;
    localparam int WSQ_W        = 2 * DATA_W + WEIGHT_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_ONE = 1 << FRAC_W;
    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(1 << FRAC_W);
    localparam logic [WEIGHT_W-1:0] W_MAX = '1;

    localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(1 << (FRAC_W - 1));
    localparam logic signed [EXT_W-1:0] SOL_MAX  = EXT_W'(Q_MAX);
    localparam logic signed [EXT_W-1:0] SOL_MIN  = -SOL_MAX - 1;

    typedef struct {
        logic signed [DATA_W-1:0] dir;
        logic signed [DATA_W-1:0] op_dir;
        logic signed [DATA_W-1:0] sol;
        logic signed [DATA_W-1:0] res;
        logic [WEIGHT_W-1:0]      wgt;
        logic                     last;
    } node_t;

    typedef struct {
        logic signed [DATA_W-1:0] sol;
        logic signed [DATA_W-1:0] res;
        logic                     norm_valid;
        logic [NORM_W-1:0]        norm;
    } update_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic        [DATA_W-1:0]   cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [DATA_W-1:0]   dir_value = '0;
    logic signed [DATA_W-1:0]   op_dir_value = '0;
    logic signed [DATA_W-1:0]   sol_value = '0;
    logic signed [DATA_W-1:0]   res_value = '0;
    logic        [WEIGHT_W-1:0] weight = '0;
    logic                       last_item = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DATA_W-1:0]   new_sol;
    logic signed [DATA_W-1:0]   new_res;
    logic                       norm_valid;
    logic        [NORM_W-1:0]   weighted_norm;

    // predictor state
    logic signed [DATA_W-1:0] alpha_q16 = '0;
    logic [NORM_W-1:0]        norm_sum = '0;
    update_t                  predicted_updates[$];

    int  cycle_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  norms_checked = 0;
    int  alpha_writes = 0;
    int  mismatches = 0;
    int  hold_req = 0;
    bit  idle_enable = 1'b1;

    cg_update_weighted_norm_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dir_value     (dir_value),
        .op_dir_value  (op_dir_value),
        .sol_value     (sol_value),
        .res_value     (res_value),
        .weight        (weight),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_sol       (new_sol),
        .new_res       (new_res),
        .norm_valid    (norm_valid),
        .weighted_norm (weighted_norm)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Round half up from Q32.32 to Q16.16 and clamp to the signed range.
    function automatic logic signed [DATA_W-1:0] round_sat_q16(
        input logic signed [EXT_W-1:0] exact);
        logic signed [EXT_W-1:0] q;
        q = (exact + HALF_LSB) >>> FRAC_W;
        if (q > SOL_MAX)
            return Q_MAX;
        if (q < SOL_MIN)
            return Q_MIN;
        return q[DATA_W-1:0];
    endfunction

    function automatic update_t cg_step(input node_t n);
        logic signed [EXT_W-1:0]          a, p, ap, x, r;
        logic [DATA_W-1:0]                mag;
        logic [2*DATA_W-1:0]              sq;
        logic [WSQ_W-1:0]                 wsq;
        logic [NORM_W-1:0]                term;
        logic [NORM_W:0]                  sum;
        update_t                          u;
        a  = EXT_W'(alpha_q16);
        p  = EXT_W'(n.dir);
        ap = EXT_W'(n.op_dir);
        x  = EXT_W'(n.sol);
        r  = EXT_W'(n.res);
        u.sol = round_sat_q16((x <<< FRAC_W) + a * p);
        u.res = round_sat_q16((r <<< FRAC_W) - a * ap);
        mag = u.res[DATA_W-1] ? -u.res : u.res;
        sq = (2*DATA_W)'(mag) * (2*DATA_W)'(mag);
        // Q32.32 square times Q1.16 weight, rounded back to Q32.32
        wsq = (WSQ_W'(sq) * WSQ_W'(n.wgt) + WSQ_W'(HALF_LSB[FRAC_W-1:0])) >> FRAC_W;
        term = (wsq[WSQ_W-1:NORM_W] != '0) ? NORM_MAX : wsq[NORM_W-1:0];
        sum = {1'b0, norm_sum} + {1'b0, term};
        norm_sum = sum[NORM_W] ? NORM_MAX : sum[NORM_W-1:0];
        u.norm_valid = n.last;
        u.norm = n.last ? norm_sum : '0;
        if (n.last)
            norm_sum = '0;
        return u;
    endfunction

    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    default: return '1;
                endcase
            1, 2, 3: return $urandom_range(0, 1 << 21) - (1 << 20);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_alpha();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            1, 2, 3, 4, 5: return $urandom_range(0, 1 << 19) - (1 << 18);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return W_ONE;
            2: return WEIGHT_W'($urandom_range(W_ONE + 1, W_MAX));
            default: return WEIGHT_W'($urandom_range(0, W_ONE));
        endcase
    endfunction

    function automatic node_t mk_node(input logic [DATA_W-1:0] dir, op_dir, sol, res,
                                      input logic [WEIGHT_W-1:0] wgt, input logic last);
        node_t n;
        n.dir = dir;
        n.op_dir = op_dir;
        n.sol = sol;
        n.res = res;
        n.wgt = wgt;
        n.last = last;
        return n;
    endfunction

    // Offer one node, hold it until the transfer, then record its prediction.
    task automatic send_node(input node_t n);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        dir_value    <= n.dir;
        op_dir_value <= n.op_dir;
        sol_value    <= n.sol;
        res_value    <= n.res;
        weight       <= n.wgt;
        last_item    <= n.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_updates.push_back(cg_step(n));
        items_sent++;
    endtask

    // Drain the block, then write alpha while nothing is in flight.
    task automatic write_alpha(input logic [DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        alpha_q16 = value;
        alpha_writes++;
    endtask

    task automatic run_passes(input int n_items, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, max_len);
            // a stray last flag now and then splits a pass early
            for (int i = 0; i < len; i++)
                send_node(mk_node(rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                                  rand_weight(), i == len - 1 || $urandom_range(0, 39) == 0));
            sent += len;
        end
    endtask

    // alpha still at its reset value: x and r pass through unchanged
    task automatic test_reset_alpha();
        send_node(mk_node(Q_MAX, Q_MIN, 32'sd123456, -32'sd98765, W_ONE, 1'b0));
        send_node(mk_node(Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, 1'b1));
    endtask

    // alpha = 2^-16 puts alpha*p exactly on the half step
    task automatic test_rounding();
        write_alpha(32'd1);
        send_node(mk_node(32'sh8000, 32'sh8000, 32'sd5, -32'sd5, 17'd1, 1'b0));
        send_node(mk_node(-32'sh8000, -32'sh8000, 32'sd5, -32'sd5, 17'd1, 1'b0));
        send_node(mk_node(32'sh7FFF, -32'sh7FFF, -32'sd5, 32'sd5, W_ONE, 1'b0));
        send_node(mk_node(-32'sh8001, 32'sh8001, '0, '0, W_ONE, 1'b1));
    endtask

    task automatic test_saturation();
        write_alpha(Q_MAX);
        send_node(mk_node(Q_MAX, Q_MAX, Q_MAX, Q_MIN, W_MAX, 1'b0));
        send_node(mk_node(Q_MIN, Q_MIN, Q_MIN, Q_MAX, W_ONE, 1'b0));
        send_node(mk_node(Q_ONE, '1, '0, '0, W_ONE, 1'b1));
        write_alpha(Q_MIN);
        send_node(mk_node(Q_MIN, Q_MIN, '0, Q_MAX, W_MAX, 1'b0));
        send_node(mk_node(Q_MAX, Q_MAX, Q_MIN, Q_MIN, W_ONE, 1'b1));
    endtask

    // push the sum to its ceiling, hold it there, report and clear it
    task automatic test_norm_saturation();
        write_alpha('0);
        send_node(mk_node('0, '0, '0, Q_MIN, W_MAX, 1'b0));
        send_node(mk_node('0, '0, '0, Q_MAX, W_MAX, 1'b0));
        send_node(mk_node('0, '0, '0, '0, '0, 1'b1));
        send_node(mk_node('0, '0, '0, 32'sd1, W_ONE, 1'b1));
        send_node(mk_node('0, '0, '0, -32'sd1, W_MAX, 1'b1));
    endtask

    task automatic test_weight_bits();
        write_alpha('1);
        send_node(mk_node(32'sh0001_5555, 32'shFFFE_AAAA, 32'sh0003_0000, 32'sh0002_8000,
                          '0, 1'b0));
        send_node(mk_node(-32'sh0001_5555, 32'sh0001_5555, -32'sh0003_0000, -32'sh0002_8000,
                          17'h1, 1'b0));
        send_node(mk_node(Q_ONE, -Q_ONE, 32'sh00AA_0000, 32'sh0055_0000, W_ONE, 1'b0));
        send_node(mk_node(32'sh1234_5678, 32'sh7654_3210, 32'sh0FED_CBA9, 32'sh0001_2345,
                          W_MAX, 1'b0));
        send_node(mk_node(32'sh0000_FFFF, 32'sh0000_0001, 32'sh0000_0100, 32'sh0000_7FFF,
                          17'h15555, 1'b0));
        send_node(mk_node(32'sh5A5A_A5A5, 32'shA5A5_5A5A, 32'sh3C3C_C3C3, 32'sh0000_C3C3,
                          17'h0AAAA, 1'b1));
    endtask

    task automatic test_random_passes();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_alpha(rand_alpha());
            run_passes(260, 40);
        end
    endtask

    // receiver holds off while the sender keeps offering: the block fills and stalls
    task automatic test_output_backpressure();
        idle_enable = 1'b0;
        write_alpha($urandom_range(0, 1 << 18) - (1 << 17));
        hold_req = 400;
        run_passes(40, 16);
    endtask

    task automatic test_steady_stream();
        idle_enable = 1'b0;
        write_alpha(rand_alpha());
        run_passes(300, 64);
    endtask

    // receiver side: random stall bursts plus the long hold-off on request
    initial
    begin : stall_gen
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req > 0)
            begin
                stall_left = hold_req - 1;
                hold_req = 0;
                out_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : result_check
        update_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (predicted_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: sol %h res %h norm_valid %b norm %h",
                                 new_sol, new_res, norm_valid, weighted_norm);
                end
                else
                begin
                    want = predicted_updates.pop_front();
                    results_checked++;
                    if (want.norm_valid)
                        norms_checked++;
                    if (new_sol !== want.sol || new_res !== want.res
                        || norm_valid !== want.norm_valid || weighted_norm !== want.norm)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: sol %h/%h res %h/%h nv %b/%b norm %h/%h",
                                     results_checked, want.sol, new_sol, want.res, new_res,
                                     want.norm_valid, norm_valid, want.norm, weighted_norm);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout at cycle %0d with %0d results outstanding",
                 cycle_count, predicted_updates.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_alpha();
        test_rounding();
        test_saturation();
        test_norm_saturation();
        test_weight_bits();
        test_random_passes();
        test_output_backpressure();
        test_steady_stream();

        in_valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transfers in, %0d results checked, %0d norms reported, %0d alpha settings",
                 items_sent, results_checked, norms_checked, alpha_writes);
        $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
        if (mismatches == 0 && predicted_updates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cgwn_pkg.sv
sv/cgwn_ctrl.sv
sv/cgwn_dpath.sv
sv/cg_update_weighted_norm_unit.sv
tb/cg_update_weighted_norm_unit_tb.sv
